// File: hdl/sitda_pkg.sv
// Shared constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

    // Input integer width and default decimal digit count
    localparam int BIN_WIDTH          = 32;
    localparam int DEFAULT_NUM_DIGITS = 10;

    // Output character width and codes
    localparam int         CHAR_WIDTH = 7;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    // BCD digit width and the threshold for the add-3 adjust
    localparam int         BCD_WIDTH  = 4;
    localparam logic [3:0] ADJ_LIMIT  = 4'd5;
    localparam logic [3:0] ADJ_OFFSET = 4'd3;

endpackage

// File: hdl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//  channel | dir | fields (low bit first)               | item
//  s_      | in  | tdata: number[31:0]                  | one integer
//  m_      | out | tdata: char_code[6:0], zero pad [7]  | one character
//          |     | tlast: is_last                       |
//
// An item is accepted, then converted bit by bit through the shared
// shift-and-add-3 unit, then scanned over NUM_DIGITS digits, each scan
// step emitting one digit or skipping one leading zero. The sign character
// goes out as soon as the output slot is free, before any digit. Output
// stalls hold the scan at a digit to emit; s_tready is high only when idle.
// Reset (aresetn low, synchronous) returns to idle and empties the output.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
    parameter int NUM_DIGITS = sitda_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast    // is_last
);
    import sitda_pkg::*;

    localparam int BCD_BITS  = NUM_DIGITS * BCD_WIDTH;
    localparam int BIT_CNT_W = $clog2(BIN_WIDTH);
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [BIN_WIDTH-1:0]    mag_reg, mag_next;
    logic [BCD_BITS-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    logic                    sign_pend_reg, sign_pend_next;
    logic                    started_reg, started_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CHAR_WIDTH-1:0]   m_char_reg, m_char_next;
    logic                    m_last_reg, m_last_next;

    logic                    in_accept;
    logic                    out_free;
    logic [BCD_BITS-1:0]     bcd_step;
    logic [BCD_WIDTH-1:0]    top_digit;
    logic                    at_last_digit;
    logic                    show_digit;
    logic [BIN_WIDTH-1:0]    in_mag;

    assign in_accept     = s_tvalid && s_tready;
    assign out_free      = !m_valid_reg || m_tready;
    assign top_digit     = bcd_reg[BCD_BITS-1 -: BCD_WIDTH];
    assign at_last_digit = (dig_cnt_reg == DIG_CNT_W'(1));
    assign show_digit    = (top_digit != '0) || started_reg || at_last_digit;
    assign in_mag        = s_tdata[BIN_WIDTH-1] ? (~s_tdata + BIN_WIDTH'(1)) : s_tdata;

    // Shared conversion step
    sitda_dabble #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (mag_reg[BIN_WIDTH-1]),
        .bcd_out (bcd_step)
    );

    // Sequencer: load, convert bit by bit, then scan digits from the top
    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        sign_pend_next = sign_pend_reg;
        started_next   = started_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    mag_next       = in_mag;
                    bcd_next       = '0;
                    bit_cnt_next   = '0;
                    sign_pend_next = s_tdata[BIN_WIDTH-1];
                    state_next     = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = bcd_step;
                mag_next     = {mag_reg[BIN_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(BIN_WIDTH - 1)) begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!show_digit) begin
                    // Drop a leading zero
                    bcd_next     = bcd_reg << BCD_WIDTH;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end else if (out_free && !sign_pend_reg) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO + CHAR_WIDTH'(top_digit);
                    m_last_next  = at_last_digit;
                    started_next = 1'b1;
                    bcd_next     = bcd_reg << BCD_WIDTH;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    if (at_last_digit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Send the sign as soon as the output slot frees up
        if (!(state_reg == ST_IDLE) && sign_pend_reg && out_free) begin
            m_valid_next   = 1'b1;
            m_char_next    = CHAR_MINUS;
            m_last_next    = 1'b0;
            sign_pend_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            sign_pend_reg <= 1'b0;
            started_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            sign_pend_reg <= sign_pend_next;
            started_reg   <= started_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // Digits seen by the scan are valid BCD
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (top_digit <= 4'd9))
        else $error("non-BCD digit in scan");

    // The sign goes out before the number finishes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sign_pend_reg)
        else $error("sign still pending when idle");

    // The sign character never closes a number
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_char_reg == CHAR_MINUS)) |-> !m_last_reg)
        else $error("sign marked as last");

    // An accepted item starts conversion from bit zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> ((state_reg == ST_CONV) && (bit_cnt_reg == '0)))
        else $error("conversion did not start");

    // Output characters are a minus sign or a decimal digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_char_reg == CHAR_MINUS) ||
                         ((m_char_reg >= CHAR_ZERO) && (m_char_reg <= CHAR_ZERO + 7'd9))))
        else $error("bad output character");
`endif

endmodule

// File: hdl/sitda_dabble.sv
// One shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps

module sitda_dabble #(
    parameter int NUM_DIGITS = sitda_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic [NUM_DIGITS*sitda_pkg::BCD_WIDTH-1:0] bcd_in,
    input  logic                                       bit_in,
    output logic [NUM_DIGITS*sitda_pkg::BCD_WIDTH-1:0] bcd_out
);
    import sitda_pkg::*;

    localparam int BCD_BITS = NUM_DIGITS * BCD_WIDTH;

    logic [BCD_BITS-1:0] adjusted;

    // Add 3 to every digit of 5 or more so the shift carries into the next digit
    always_comb begin
        logic [BCD_WIDTH-1:0] digit;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digit = bcd_in[i*BCD_WIDTH +: BCD_WIDTH];
            if (digit >= ADJ_LIMIT) begin
                adjusted[i*BCD_WIDTH +: BCD_WIDTH] = digit + ADJ_OFFSET;
            end else begin
                adjusted[i*BCD_WIDTH +: BCD_WIDTH] = digit;
            end
        end
    end

    // Shift in the next binary bit; the carry out of the top digit is dropped
    assign bcd_out = {adjusted[BCD_BITS-2:0], bit_in};

endmodule
